FILE: design/pif_pkg.sv
package pif_pkg;

   localparam int ARG_BITS_DEF  = 32;
   localparam int FIELD_MAX_DEF = 63;

   localparam int CHAR_W  = 8;
   localparam int ARG_W   = 32;
   localparam int FIELD_W = 6;
   localparam int POS_W   = 7;
   localparam int FLAG_W  = 11;
   localparam int MAX_OUT = 63;

   localparam int FL_ESC   = 0;
   localparam int FL_UNS   = 1;
   localparam int FL_CAP   = 2;
   localparam int FL_WID   = 3;
   localparam int FL_PREC  = 4;
   localparam int FL_SPACE = 5;
   localparam int FL_ZERO  = 6;
   localparam int FL_PLUS  = 7;
   localparam int FL_MINUS = 8;
   localparam int FL_SHORT = 9;
   localparam int FL_LONG  = 10;

   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PCT     = 8'h25;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;
   localparam logic [CHAR_W-1:0] CH_UP_L    = 8'h4C;
   localparam logic [CHAR_W-1:0] CH_UP_N    = 8'h4E;
   localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LO_C    = 8'h63;
   localparam logic [CHAR_W-1:0] CH_LO_D    = 8'h64;
   localparam logic [CHAR_W-1:0] CH_LO_H    = 8'h68;
   localparam logic [CHAR_W-1:0] CH_LO_I    = 8'h69;
   localparam logic [CHAR_W-1:0] CH_LO_L    = 8'h6C;
   localparam logic [CHAR_W-1:0] CH_LO_O    = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_LO_P    = 8'h70;
   localparam logic [CHAR_W-1:0] CH_LO_U    = 8'h75;
   localparam logic [CHAR_W-1:0] CH_LO_X    = 8'h78;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_SCAN,
      ST_PLAN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_CHAR,
      KIND_DEC,
      KIND_RADIX
   } kind_type;

   typedef struct packed {
      logic accept;
      logic dabble_step;
      logic scan_step;
      logic plan;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     out_free;
      logic     dabble_last;
      logic     scan_done;
      logic     emit_last;
   } status_type;

endpackage

FILE: design/pif_req_if.sv
interface pif_req_if;
   logic                         valid;
   logic                         ready;
   logic [pif_pkg::CHAR_W-1:0]   fmt_char;
   logic [pif_pkg::ARG_W-1:0]    arg_value;

   modport source (output valid, output fmt_char, output arg_value, input ready);
   modport sink (input valid, input fmt_char, input arg_value, output ready);
endinterface

FILE: design/pif_rsp_if.sv
interface pif_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pif_pkg::CHAR_W-1:0]   out_char;
   logic                         last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink (input valid, input out_char, input last, output ready);
endinterface

FILE: design/printf_integer_formatter.sv
// Integer formatter for printf-style format strings.
// The req channel carries one format character per transfer, with the argument
// word used when that character completes a conversion. The rsp channel returns
// the produced characters one per transfer; last marks the final character of
// an input. Inputs that produce nothing (flags, digits, nul) return no transfer.
// A plain character, c or %% appears on rsp the cycle after it is taken.
// A hex or octal conversion scans down from the top digit position to find the
// top digit, takes a single planning step, then emits one character per cycle
// while the receiver reads. Decimal first runs a binary-to-BCD conversion.
// The controller handles one input at a time, so a conversion finishes its setup
// and all its output characters before the next input is taken; plain characters go
// at one per cycle while the receiver keeps reading.
// When the receiver stalls, the held rsp character stays put and the block
// waits; a new input is taken only when the output register is free or is
// being read in the same cycle.
// Reset is synchronous: it closes any open escape, clears width and precision,
// and drops any pending result.
module printf_integer_formatter #(
   parameter int ARG_BITS  = pif_pkg::ARG_BITS_DEF,
   parameter int FIELD_MAX = pif_pkg::FIELD_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   pif_req_if.sink   req_chan,
   pif_rsp_if.source rsp_chan
);

   pif_pkg::cmd_type    cmd;
   pif_pkg::status_type sts;

   pif_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pif_datapath #(
      .ARG_BITS  (ARG_BITS),
      .FIELD_MAX (FIELD_MAX)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_fmt_char  (req_chan.fmt_char),
      .req_arg_value (req_chan.arg_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_out_char  (rsp_chan.out_char),
      .rsp_last      (rsp_chan.last)
   );

endmodule

FILE: design/pif_controller.sv
module pif_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pif_pkg::status_type sts,
   output pif_pkg::cmd_type    cmd
);

   pif_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pif_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         pif_pkg::ST_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               cmd.accept = 1'b1;
               if (sts.kind == pif_pkg::KIND_DEC) begin
                  state_in = pif_pkg::ST_DABBLE;
               end else if (sts.kind == pif_pkg::KIND_RADIX) begin
                  state_in = pif_pkg::ST_SCAN;
               end
            end
         end
         pif_pkg::ST_DABBLE: begin
            cmd.dabble_step = 1'b1;
            if (sts.dabble_last) begin
               state_in = pif_pkg::ST_SCAN;
            end
         end
         pif_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = pif_pkg::ST_PLAN;
            end
         end
         pif_pkg::ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = pif_pkg::ST_EMIT;
         end
         pif_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_step = 1'b1;
               if (sts.emit_last) begin
                  state_in = pif_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = pif_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/pif_datapath.sv
module pif_datapath #(
   parameter int ARG_BITS  = pif_pkg::ARG_BITS_DEF,
   parameter int FIELD_MAX = pif_pkg::FIELD_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pif_pkg::CHAR_W-1:0]  req_fmt_char,
   input  logic [pif_pkg::ARG_W-1:0]   req_arg_value,
   input  pif_pkg::cmd_type            cmd,
   output pif_pkg::status_type         sts,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pif_pkg::CHAR_W-1:0]  rsp_out_char,
   output logic                        rsp_last
);

   localparam int NDIG  = (ARG_BITS + 2) / 3;
   localparam int NHEX  = (ARG_BITS + 3) / 4;
   localparam int IDX_W = $clog2(NDIG);
   localparam int CNT_W = $clog2(ARG_BITS);
   localparam int PW    = pif_pkg::POS_W;
   localparam int FW    = pif_pkg::FIELD_W;

   logic [pif_pkg::FLAG_W-1:0] flags_ff, flags_in, fl;
   logic [FW-1:0]              width_ff, width_in, prec_ff, prec_in;
   logic [9:0]                 acc;
   pif_pkg::kind_type          kind;
   logic [pif_pkg::CHAR_W-1:0] single_char, ch;
   logic                       neg;
   logic [ARG_BITS-1:0]        arg_val, mag;
   logic [NDIG*3-1:0]          mag_oct;
   logic [NHEX*4-1:0]          mag_hex;
   logic [NDIG*4-1:0]          bcd_ff, bcd_in, adj, radix_digits;
   logic [ARG_BITS-1:0]        sh_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [IDX_W-1:0]           idx_ff, dig_idx;
   logic [3:0]                 cur_dig, emit_dig;
   logic                       cv_minus_ff, cv_zero_ff, cv_plus_ff, cv_cap_ff;
   logic [pif_pkg::CHAR_W-1:0] cv_sig_ff;
   logic [PW-1:0]              size, prec7, width7, body, plen, pad, lead, t1, t2, pz, t3, t4;
   logic [PW-1:0]              total;
   logic [PW-1:0]              t0_ff, t1_ff, t3_ff, t4_ff, total_ff, pos_ff;
   logic [pif_pkg::CHAR_W-1:0] emit_char, dig_char;
   logic                       rsp_valid_ff, last_ff;
   logic [pif_pkg::CHAR_W-1:0] out_char_ff;

   assign ch      = req_fmt_char;
   assign arg_val = ARG_BITS'(req_arg_value);

   always_comb begin
      flags_in    = flags_ff;
      width_in    = width_ff;
      prec_in     = prec_ff;
      kind        = pif_pkg::KIND_NONE;
      single_char = ch;
      fl          = flags_ff;
      acc         = '0;
      if (ch == pif_pkg::CH_NUL) begin
         flags_in = '0;
      end else if (!flags_ff[pif_pkg::FL_ESC]) begin
         if (ch == pif_pkg::CH_PCT) begin
            flags_in                  = '0;
            flags_in[pif_pkg::FL_ESC] = 1'b1;
            width_in                  = '0;
            prec_in                   = '0;
         end else begin
            kind = pif_pkg::KIND_CHAR;
         end
      end else begin
         case (ch)
            pif_pkg::CH_LO_H, pif_pkg::CH_UP_N: fl[pif_pkg::FL_SHORT] = 1'b1;
            pif_pkg::CH_LO_L, pif_pkg::CH_UP_F, pif_pkg::CH_UP_L: fl[pif_pkg::FL_LONG] = 1'b1;
            pif_pkg::CH_LO_U: begin
               fl[pif_pkg::FL_UNS] = 1'b1;
               kind                = pif_pkg::KIND_DEC;
            end
            pif_pkg::CH_LO_D, pif_pkg::CH_LO_I: kind = pif_pkg::KIND_DEC;
            pif_pkg::CH_LO_O, pif_pkg::CH_LO_X, pif_pkg::CH_LO_P: begin
               fl[pif_pkg::FL_UNS] = 1'b1;
               kind                = pif_pkg::KIND_RADIX;
            end
            pif_pkg::CH_UP_X: begin
               fl[pif_pkg::FL_UNS] = 1'b1;
               fl[pif_pkg::FL_CAP] = 1'b1;
               kind                = pif_pkg::KIND_RADIX;
            end
            pif_pkg::CH_LO_C: begin
               kind        = pif_pkg::KIND_CHAR;
               single_char = req_arg_value[pif_pkg::CHAR_W-1:0];
               fl          = '0;
            end
            pif_pkg::CH_PCT: begin
               kind = pif_pkg::KIND_CHAR;
               fl   = '0;
            end
            pif_pkg::CH_PLUS:  fl[pif_pkg::FL_PLUS] = 1'b1;
            pif_pkg::CH_MINUS: fl[pif_pkg::FL_MINUS] = 1'b1;
            pif_pkg::CH_SPACE: fl[pif_pkg::FL_SPACE] = 1'b1;
            pif_pkg::CH_DOT:   fl[pif_pkg::FL_PREC] = 1'b1;
            default: begin
               if (ch >= pif_pkg::CH_ZERO && ch <= pif_pkg::CH_NINE) begin
                  if (ch == pif_pkg::CH_ZERO && !fl[pif_pkg::FL_WID] && !fl[pif_pkg::FL_PREC]) begin
                     fl[pif_pkg::FL_ZERO] = 1'b1;
                  end
                  if (fl[pif_pkg::FL_PREC]) begin
                     acc = 10'(prec_ff) * 10'd10 + 10'(ch[3:0]);
                     prec_in = (acc > 10'(FIELD_MAX - 1)) ? FW'(FIELD_MAX - 1) : acc[FW-1:0];
                  end else begin
                     acc = 10'(width_ff) * 10'd10 + 10'(ch[3:0]);
                     width_in = (acc > 10'(FIELD_MAX)) ? FW'(FIELD_MAX) : acc[FW-1:0];
                     fl[pif_pkg::FL_WID] = 1'b1;
                  end
               end else begin
                  fl = '0;
               end
            end
         endcase
         flags_in = (kind == pif_pkg::KIND_DEC || kind == pif_pkg::KIND_RADIX) ? '0 : fl;
      end
   end

   assign neg     = !fl[pif_pkg::FL_UNS] && arg_val[ARG_BITS-1];
   assign mag     = neg ? (~arg_val + 1'b1) : arg_val;
   assign mag_oct = (NDIG*3)'(mag);
   assign mag_hex = (NHEX*4)'(mag);

   always_comb begin
      radix_digits = '0;
      for (int i = 0; i < NDIG; i++) begin
         if (ch == pif_pkg::CH_LO_O) begin
            radix_digits[i*4 +: 4] = {1'b0, mag_oct[i*3 +: 3]};
         end else if (i < NHEX) begin
            radix_digits[i*4 +: 4] = mag_hex[i*4 +: 4];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3 : bcd_ff[i*4 +: 4];
      end
      bcd_in = {adj[NDIG*4-2:0], sh_ff[ARG_BITS-1]};
   end

   assign cur_dig = bcd_ff[{idx_ff, 2'b00} +: 4];

   always_comb begin
      size   = PW'(idx_ff) + 1'b1;
      prec7  = PW'(prec_ff);
      width7 = PW'(width_ff);
      body   = (size > prec7) ? size : prec7;
      plen   = body + PW'(cv_plus_ff);
      pad    = (width7 > plen) ? width7 - plen : '0;
      lead   = (!cv_minus_ff && !cv_zero_ff) ? pad : '0;
      t1     = lead + PW'(cv_plus_ff);
      t2     = t1 + (cv_zero_ff ? pad : '0);
      pz     = (prec7 > size) ? prec7 - size : '0;
      t3     = t2 + pz;
      t4     = t3 + size;
      total  = t4 + (cv_minus_ff ? pad : '0);
   end

   always_comb begin
      dig_idx  = IDX_W'(t4_ff - pos_ff - 1'b1);
      emit_dig = bcd_ff[{dig_idx, 2'b00} +: 4];
      if (emit_dig >= 4'd10) begin
         dig_char = 8'(emit_dig) + pif_pkg::CH_ZERO + (pif_pkg::CH_UPPER_A - pif_pkg::CH_COLON)
                    + (cv_cap_ff ? 8'd0 : pif_pkg::CH_SPACE);
      end else begin
         dig_char = 8'(emit_dig) + pif_pkg::CH_ZERO;
      end
      priority if (pos_ff < t0_ff) begin
         emit_char = pif_pkg::CH_SPACE;
      end else if (pos_ff < t1_ff) begin
         emit_char = cv_sig_ff;
      end else if (pos_ff < t3_ff) begin
         emit_char = pif_pkg::CH_ZERO;
      end else if (pos_ff < t4_ff) begin
         emit_char = dig_char;
      end else begin
         emit_char = pif_pkg::CH_SPACE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         width_ff     <= '0;
         prec_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            flags_ff <= flags_in;
            width_ff <= width_in;
            prec_ff  <= prec_in;
         end
         if (cmd.accept && kind == pif_pkg::KIND_CHAR) begin
            rsp_valid_ff <= 1'b1;
         end else if (cmd.emit_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && kind == pif_pkg::KIND_CHAR) begin
         out_char_ff <= single_char;
         last_ff     <= 1'b1;
      end else if (cmd.emit_step) begin
         out_char_ff <= emit_char;
         last_ff     <= sts.emit_last;
      end
      if (cmd.accept) begin
         cv_minus_ff <= fl[pif_pkg::FL_MINUS];
         cv_zero_ff  <= fl[pif_pkg::FL_ZERO] && !fl[pif_pkg::FL_PREC] && !fl[pif_pkg::FL_MINUS];
         cv_plus_ff  <= fl[pif_pkg::FL_PLUS] || neg || fl[pif_pkg::FL_SPACE];
         cv_cap_ff   <= fl[pif_pkg::FL_CAP];
         cv_sig_ff   <= neg ? pif_pkg::CH_MINUS :
                        (fl[pif_pkg::FL_PLUS] ? pif_pkg::CH_PLUS :
                         (fl[pif_pkg::FL_SPACE] ? pif_pkg::CH_SPACE : pif_pkg::CH_PLUS));
         idx_ff      <= IDX_W'(NDIG - 1);
         cnt_ff      <= '0;
         sh_ff       <= mag;
         bcd_ff      <= (kind == pif_pkg::KIND_DEC) ? '0 : radix_digits;
      end else if (cmd.dabble_step) begin
         bcd_ff <= bcd_in;
         sh_ff  <= sh_ff << 1;
         cnt_ff <= cnt_ff + 1'b1;
      end else if (cmd.scan_step && !sts.scan_done) begin
         idx_ff <= idx_ff - 1'b1;
      end
      if (cmd.plan) begin
         t0_ff    <= lead;
         t1_ff    <= t1;
         t3_ff    <= t3;
         t4_ff    <= t4;
         total_ff <= total;
         pos_ff   <= '0;
      end else if (cmd.emit_step) begin
         pos_ff <= pos_ff + 1'b1;
      end
   end

   always_comb begin
      sts             = '0;
      sts.kind        = kind;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
      sts.dabble_last = (cnt_ff == CNT_W'(ARG_BITS - 1));
      sts.scan_done   = (cur_dig != 4'd0) || (idx_ff == '0);
      sts.emit_last   = (pos_ff == total_ff - 1'b1);
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = last_ff;

`ifndef SYNTHESIS
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |-> (pos_ff < total_ff))
      else $error("Emit position ran past the planned field length.");

   a_char_is_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && kind == pif_pkg::KIND_CHAR) |=> (rsp_valid_ff && last_ff))
      else $error("Single character result was not marked as the final transfer.");

   a_plan_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.plan |=> ((total_ff <= PW'(pif_pkg::MAX_OUT)) && (total_ff != '0)))
      else $error("Planned conversion length is outside the legal range.");
`endif

endmodule

FILE: tb/sv/tb_printf_integer_formatter.sv
`timescale 1ns / 100ps

module tb_printf_integer_formatter;

   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 36;

   typedef struct {
      logic [pif_pkg::CHAR_W-1:0] ch;
      logic [pif_pkg::ARG_W-1:0]  arg;
   } fmt_item_type;

   typedef struct {
      logic [pif_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } text_char_type;

   typedef struct {
      logic [pif_pkg::CHAR_W-1:0] ch;
      logic [pif_pkg::ARG_W-1:0]  arg;
      int                         n_fixed;
      logic [pif_pkg::CHAR_W-1:0] fixed_ch;
   } stim_row_type;

   logic clock;
   logic reset;

   pif_req_if req_chan ();
   pif_rsp_if rsp_chan ();

   printf_integer_formatter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   logic [pif_pkg::FLAG_W-1:0]  fmt_flags;
   logic [pif_pkg::FIELD_W-1:0] fmt_width;
   logic [pif_pkg::FIELD_W-1:0] fmt_prec;

   text_char_type expected_text[$];
   fmt_item_type  send_queue[$];
   int            error_count;
   int            char_count;
   int            cycle_count;
   int            conversions;
   bit            sending_done;
   bit            calm_phase;
   bit            hold_rsp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void put_char(ref logic [pif_pkg::CHAR_W-1:0] buf_q[$],
                                    input logic [7:0] c);
      if (buf_q.size() < pif_pkg::MAX_OUT) buf_q.push_back(c);
   endfunction

   function automatic void format_integer(ref logic [pif_pkg::CHAR_W-1:0] buf_q[$],
                                          input logic [pif_pkg::ARG_W-1:0] arg,
                                          input int radix,
                                          input logic [pif_pkg::FLAG_W-1:0] flags_in);
      logic [pif_pkg::FLAG_W-1:0] fl;
      logic [pif_pkg::ARG_W-1:0]  val;
      logic [7:0]                 sig;
      logic [7:0]                 digs[$];
      int                         c;
      int                         len;
      int                         pad;
      int                         prec;
      fl = flags_in;
      val = arg;
      sig = pif_pkg::CH_PLUS;
      prec = fmt_prec;
      if (fl[pif_pkg::FL_PREC] || fl[pif_pkg::FL_MINUS]) fl[pif_pkg::FL_ZERO] = 1'b0;
      if (!fl[pif_pkg::FL_UNS] && val[pif_pkg::ARG_W-1]) begin
         fl[pif_pkg::FL_PLUS] = 1'b1;
         sig = pif_pkg::CH_MINUS;
         val = -val;
      end
      if (fl[pif_pkg::FL_SPACE] && !fl[pif_pkg::FL_PLUS]) begin
         fl[pif_pkg::FL_PLUS] = 1'b1;
         sig = pif_pkg::CH_SPACE;
      end
      do begin
         c = val % radix;
         val = val / radix;
         if (c >= 10) begin
            c += pif_pkg::CH_UPPER_A - pif_pkg::CH_COLON;
            if (!fl[pif_pkg::FL_CAP]) c += pif_pkg::CH_SPACE;
         end
         digs.push_back(8'(c + pif_pkg::CH_ZERO));
      end while (val != 0);
      len = digs.size() > prec ? digs.size() : prec;
      if (fl[pif_pkg::FL_PLUS]) len++;
      pad = fmt_width > len ? fmt_width - len : 0;
      if (!fl[pif_pkg::FL_MINUS] && !fl[pif_pkg::FL_ZERO]) begin
         for (; pad > 0; pad--) put_char(buf_q, pif_pkg::CH_SPACE);
      end
      if (fl[pif_pkg::FL_PLUS]) put_char(buf_q, sig);
      if (fl[pif_pkg::FL_ZERO]) for (; pad > 0; pad--) put_char(buf_q, pif_pkg::CH_ZERO);
      for (; prec > digs.size(); prec--) put_char(buf_q, pif_pkg::CH_ZERO);
      while (digs.size() > 0) put_char(buf_q, digs.pop_back());
      for (; pad > 0; pad--) put_char(buf_q, pif_pkg::CH_SPACE);
   endfunction

   // Advances the escape state for one character and writes the text it produces into buf_q.
   function automatic void format_step(input fmt_item_type it,
                                       ref logic [pif_pkg::CHAR_W-1:0] buf_q[$]);
      logic [pif_pkg::FLAG_W-1:0] fl;
      int                         radix;
      int                         v;
      fl = fmt_flags;
      radix = 0;
      buf_q.delete();
      if (it.ch == pif_pkg::CH_NUL) begin
         fmt_flags = '0;
         return;
      end
      if (!fl[pif_pkg::FL_ESC]) begin
         if (it.ch == pif_pkg::CH_PCT) begin
            fmt_flags = '0;
            fmt_flags[pif_pkg::FL_ESC] = 1'b1;
            fmt_width = '0;
            fmt_prec = '0;
         end else begin
            put_char(buf_q, it.ch);
         end
         return;
      end
      case (it.ch)
         pif_pkg::CH_LO_H, pif_pkg::CH_UP_N: fl[pif_pkg::FL_SHORT] = 1'b1;
         pif_pkg::CH_LO_L, pif_pkg::CH_UP_F, pif_pkg::CH_UP_L: fl[pif_pkg::FL_LONG] = 1'b1;
         pif_pkg::CH_LO_U: begin
            fl[pif_pkg::FL_UNS] = 1'b1;
            radix = 10;
         end
         pif_pkg::CH_LO_D, pif_pkg::CH_LO_I: radix = 10;
         pif_pkg::CH_LO_O: begin
            fl[pif_pkg::FL_UNS] = 1'b1;
            radix = 8;
         end
         pif_pkg::CH_UP_X: begin
            fl[pif_pkg::FL_UNS] = 1'b1;
            fl[pif_pkg::FL_CAP] = 1'b1;
            radix = 16;
         end
         pif_pkg::CH_LO_X, pif_pkg::CH_LO_P: begin
            fl[pif_pkg::FL_UNS] = 1'b1;
            radix = 16;
         end
         pif_pkg::CH_LO_C: begin
            put_char(buf_q, it.arg[7:0]);
            fl = '0;
         end
         pif_pkg::CH_PCT: begin
            put_char(buf_q, pif_pkg::CH_PCT);
            fl = '0;
         end
         pif_pkg::CH_PLUS:  fl[pif_pkg::FL_PLUS] = 1'b1;
         pif_pkg::CH_MINUS: fl[pif_pkg::FL_MINUS] = 1'b1;
         pif_pkg::CH_SPACE: fl[pif_pkg::FL_SPACE] = 1'b1;
         pif_pkg::CH_DOT:   fl[pif_pkg::FL_PREC] = 1'b1;
         default: begin
            if (it.ch >= pif_pkg::CH_ZERO && it.ch <= pif_pkg::CH_NINE) begin
               if (it.ch == pif_pkg::CH_ZERO && !fl[pif_pkg::FL_WID] && !fl[pif_pkg::FL_PREC]) begin
                  fl[pif_pkg::FL_ZERO] = 1'b1;
               end
               if (fl[pif_pkg::FL_PREC]) begin
                  v = fmt_prec * 10 + (it.ch - pif_pkg::CH_ZERO);
                  fmt_prec = pif_pkg::FIELD_W'(v > pif_pkg::FIELD_MAX_DEF - 1 ?
                                               pif_pkg::FIELD_MAX_DEF - 1 : v);
               end else begin
                  v = fmt_width * 10 + (it.ch - pif_pkg::CH_ZERO);
                  fmt_width = pif_pkg::FIELD_W'(v > pif_pkg::FIELD_MAX_DEF ?
                                                pif_pkg::FIELD_MAX_DEF : v);
                  fl[pif_pkg::FL_WID] = 1'b1;
               end
            end else begin
               fl = '0;
            end
         end
      endcase
      if (radix != 0) begin
         format_integer(buf_q, it.arg, radix, fl);
         fl = '0;
         conversions++;
      end
      fmt_flags = fl;
   endfunction

   task automatic queue_text(input logic [pif_pkg::CHAR_W-1:0] c,
                             input logic [pif_pkg::ARG_W-1:0] a);
      fmt_item_type it;
      it.ch = c;
      it.arg = a;
      send_queue.push_back(it);
   endtask

   task automatic queue_string(input string s, input logic [pif_pkg::ARG_W-1:0] a);
      for (int k = 0; k < s.len(); k++) queue_text(s[k], a);
   endtask

   // Sender.
   initial begin
      fmt_item_type it;
      logic [pif_pkg::CHAR_W-1:0] text_q[$];
      req_chan.valid <= 1'b0;
      req_chan.fmt_char <= '0;
      req_chan.arg_value <= '0;
      sending_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (send_queue.size() == 0 && sending_done) break;
         if (send_queue.size() == 0 || (!calm_phase && $urandom_range(99) < 21)) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end else begin
            it = send_queue.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.fmt_char <= it.ch;
            req_chan.arg_value <= it.arg;
            @(posedge clock);
            while (!req_chan.ready) @(posedge clock);
            format_step(it, text_q);
            foreach (text_q[k]) begin
               text_char_type t;
               t.ch = text_q[k];
               t.last = (k == text_q.size() - 1);
               expected_text.push_back(t);
            end
         end
      end
      req_chan.valid <= 1'b0;
   end

   // Receiver.
   initial begin
      text_char_type t;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            char_count++;
            if (expected_text.size() == 0) begin
               $error("unexpected out_char %h", rsp_chan.out_char);
               error_count++;
            end else begin
               t = expected_text.pop_front();
               if (rsp_chan.out_char !== t.ch) begin
                  $error("out_char: expected %h, actual %h", t.ch, rsp_chan.out_char);
                  error_count++;
               end
               if (rsp_chan.last !== t.last) begin
                  $error("last: expected %b, actual %b", t.last, rsp_chan.last);
                  error_count++;
               end
            end
         end
         rsp_chan.ready <= !reset && !hold_rsp && (calm_phase || $urandom_range(99) >= 21);
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Directed table: fixed expectations only for single-character results.
   stim_row_type directed[] = '{
      '{8'h41, 32'h0, 1, 8'h41},
      '{8'hFF, 32'h0, 1, 8'hFF},
      '{8'h25, 32'h0, 0, 8'h00},
      '{8'h25, 32'h0, 1, 8'h25},
      '{8'h25, 32'h0, 0, 8'h00},
      '{8'h63, 32'hFFFF_FF7E, 1, 8'h7E},
      '{8'h25, 32'h0, 0, 8'h00},
      '{8'h73, 32'h0, 0, 8'h00},
      '{8'h25, 32'h0, 0, 8'h00},
      '{8'h00, 32'h0, 0, 8'h00},
      '{8'h25, 32'h0, 0, 8'h00},
      '{8'h23, 32'h0, 0, 8'h00},
      '{8'h25, 32'h0, 0, 8'h00},
      '{8'h64, 32'h0, 1, 8'h30},
      '{8'h25, 32'h0, 0, 8'h00},
      '{8'h75, 32'h9, 1, 8'h39},
      '{8'h25, 32'h0, 0, 8'h00},
      '{8'h78, 32'hF, 1, 8'h66},
      '{8'h25, 32'h0, 0, 8'h00},
      '{8'h58, 32'hF, 1, 8'h46}
   };

   function automatic string random_spec();
      string s;
      string conv;
      s = "%";
      conv = "diuoxXp";
      if ($urandom_range(3) == 0) s = {s, "+"};
      if ($urandom_range(3) == 0) s = {s, "-"};
      if ($urandom_range(3) == 0) s = {s, " "};
      if ($urandom_range(2) == 0) s = {s, "0"};
      if ($urandom_range(1) == 0) s = {s, $sformatf("%0d", $urandom_range(20))};
      if ($urandom_range(2) == 0) s = {s, ".", $sformatf("%0d", $urandom_range(15))};
      if ($urandom_range(5) == 0) s = {s, $urandom_range(1) ? "l" : "h"};
      if ($urandom_range(9) == 0) s = {s, "99999"};
      return {s, string'(conv[$urandom_range(6)])};
   endfunction

   function automatic logic [pif_pkg::ARG_W-1:0] random_arg();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(100);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      string spec;
      logic [pif_pkg::ARG_W-1:0]   a;
      logic [pif_pkg::FLAG_W-1:0]  f0;
      logic [pif_pkg::FIELD_W-1:0] w0;
      logic [pif_pkg::FIELD_W-1:0] p0;
      error_count = 0;
      char_count = 0;
      conversions = 0;
      hold_rsp = 1'b0;
      calm_phase = 1'b0;
      fmt_flags = '0;
      fmt_width = '0;
      fmt_prec = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The fixed expectations are run through the predictor in table order.
      f0 = fmt_flags;
      w0 = fmt_width;
      p0 = fmt_prec;
      foreach (directed[k]) begin
         logic [pif_pkg::CHAR_W-1:0] q[$];
         fmt_item_type it;
         it.ch = directed[k].ch;
         it.arg = directed[k].arg;
         format_step(it, q);
         if (q.size() != directed[k].n_fixed ||
             (q.size() == 1 && q[0] != directed[k].fixed_ch)) begin
            $error("table row %0d disagrees with predictor", k);
            error_count++;
         end
         queue_text(directed[k].ch, directed[k].arg);
      end
      fmt_flags = f0;
      fmt_width = w0;
      fmt_prec = p0;
      conversions = 0;
      queue_string("%+d", 32'h7FFF_FFFF);
      queue_string("% d", 32'h8000_0000);
      queue_string("%+ 08.3i", 32'd5);
      queue_string("%-63o", 32'hFFFF_FFFF);
      queue_string("%99.99x", 32'h1234);
      queue_string("%hlhNLFu", 32'hFFFF_FFFF);
      queue_string("%063p", 32'hDEAD_BEEF);
      queue_string("%-+5d", 32'hFFFF_FFFF);

      // Long receiver hold-off while the sender keeps offering characters.
      wait (send_queue.size() == 0);
      hold_rsp = 1'b1;
      queue_string("%+40d", 32'h8000_0000);
      queue_string("abc", 32'h0);
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;

      for (int k = 0; k < N_RANDOM; k++) begin
         case ($urandom_range(9))
            0: queue_text(8'($urandom_range(255)), $urandom);
            1: queue_text(pif_pkg::CH_NUL, $urandom);
            2: begin
               queue_text(pif_pkg::CH_PCT, 0);
               queue_text(8'($urandom_range(255)), $urandom);
            end
            3: queue_text($urandom_range(1) ? pif_pkg::CH_LO_C : pif_pkg::CH_PCT, $urandom);
            default: begin
               spec = random_spec();
               a = random_arg();
               queue_string(spec, a);
            end
         endcase
         if (k == N_RANDOM / 2) begin
            wait (send_queue.size() == 0);
            calm_phase = 1'b1;
         end
         if (k == N_RANDOM / 2 + 10) begin
            wait (send_queue.size() == 0);
            calm_phase = 1'b0;
         end
      end
      sending_done = 1'b1;
      wait (send_queue.size() == 0 && !req_chan.valid);
      wait (expected_text.size() == 0);
      repeat (200) @(posedge clock);
      $display("Format characters, flag and width combinations and %0d conversions,",
               conversions);
      $display("%0d result transfers checked including a long output stall.", char_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
